@@ hw/rtl/clsc_pkg.sv @@
// Package: geometry, character codes and sequencer states of the LCD scrolling console.
`timescale 1ns / 1ps

package clsc_pkg;

    // Display geometry
    localparam int ROWS   = 2;
    localparam int COLS   = 16;
    localparam int DEPTH  = ROWS * COLS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COL_W  = $clog2(COLS + 1);
    localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;

    // Character and controller codes
    localparam logic [7:0] NEWLINE_CHAR = 8'h0A;
    localparam logic [7:0] SPACE_CHAR   = 8'h20;
    localparam logic [7:0] CMD_SET_ADDR = 8'h80;
    localparam logic [7:0] LINE_OFFSET  = 8'h40;
    localparam logic [7:0] BOTTOM_CMD   = 8'(CMD_SET_ADDR + LINE_OFFSET * 8'(ROWS - 1));

    // Bus write register select
    localparam logic RS_CMD  = 1'b0;
    localparam logic RS_DATA = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMD,
        ST_DATA,
        ST_FINAL,
        ST_CHAR
    } clsc_state_t;

endpackage

@@ hw/rtl/char_lcd_scrolling_console_core.sv @@
// Top level: character LCD scrolling console, line store plus write sequencer.
// Latency: an accepted character first moves the state register, then its first bus word is registered on m_*.
// Ordinary character: 1 word. Newline: ROWS*(COLS+1)+1 words (35); wrapping character: 36.
// Throughput: one word per cycle while the output register is free (m_valid low or m_ready high).
// m_ready low stalls the shared address counter and the sequencer.
// s_ready returns in the same cycle that the last word appears in the output register.
// Reset (aresetn low, synchronous): line store all spaces, column 0, newest row 0, idle.
`timescale 1ns / 1ps

module char_lcd_scrolling_console_core (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_char_in,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_reg_sel,
    output logic [7:0] m_bus_byte,
    output logic       m_last
);
    import clsc_pkg::*;

    clsc_state_t state_reg, state_next;

    logic [7:0]        store_reg [DEPTH];
    logic [COL_W-1:0]  column_reg;
    logic [ROW_W-1:0]  newest_reg;
    logic [ROW_W-1:0]  line_reg;
    logic [COL_W-1:0]  cnt_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [7:0]        char_reg;
    logic              pend_reg;

    logic              m_valid_reg, m_reg_sel_reg, m_last_reg;
    logic [7:0]        m_bus_byte_reg;

    logic              accept, out_free, scroll_req;
    logic [ROW_W-1:0]  newest_adv, oldest_adv;
    logic [ADDR_W-1:0] start_addr, addr_inc;
    logic              last_line, last_col;

    logic              emit, emit_sel, emit_last;
    logic [7:0]        emit_byte;
    logic              st_we;
    logic [ADDR_W-1:0] st_addr;
    logic [7:0]        st_data;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // Scroll decision and ring arithmetic
    assign scroll_req = (s_char_in == NEWLINE_CHAR) || (column_reg >= COL_W'(COLS));
    assign newest_adv = (newest_reg == ROW_W'(ROWS - 1)) ? '0 : newest_reg + 1'b1;
    assign oldest_adv = (newest_adv == ROW_W'(ROWS - 1)) ? '0 : newest_adv + 1'b1;
    assign start_addr = ADDR_W'(oldest_adv) * ADDR_W'(COLS);
    assign addr_inc   = (addr_reg == ADDR_W'(DEPTH - 1)) ? '0 : addr_reg + 1'b1;
    assign last_line  = (line_reg == ROW_W'(ROWS - 1));
    assign last_col   = (cnt_reg == COL_W'(COLS - 1));

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = scroll_req ? ST_CMD : ST_CHAR;
                end
            end
            ST_CMD: begin
                if (out_free) begin
                    state_next = ST_DATA;
                end
            end
            ST_DATA: begin
                if (out_free && last_col) begin
                    state_next = last_line ? ST_FINAL : ST_CMD;
                end
            end
            ST_FINAL: begin
                if (out_free) begin
                    state_next = pend_reg ? ST_CHAR : ST_IDLE;
                end
            end
            ST_CHAR: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Word generation and store write port
    always_comb begin
        emit      = 1'b0;
        emit_sel  = RS_CMD;
        emit_byte = CMD_SET_ADDR;
        emit_last = 1'b0;
        st_we     = 1'b0;
        st_addr   = addr_reg;
        st_data   = SPACE_CHAR;
        unique case (state_reg)
            ST_IDLE: begin
            end
            ST_CMD: begin
                emit      = out_free;
                emit_byte = 8'(CMD_SET_ADDR + LINE_OFFSET * 8'(line_reg));
            end
            ST_DATA: begin
                // the newest line is blanked as it is redrawn
                emit      = out_free;
                emit_sel  = RS_DATA;
                emit_byte = last_line ? SPACE_CHAR : store_reg[addr_reg];
                st_we     = out_free && last_line;
            end
            ST_FINAL: begin
                emit      = out_free;
                emit_byte = BOTTOM_CMD;
                emit_last = !pend_reg;
            end
            ST_CHAR: begin
                emit      = out_free;
                emit_sel  = RS_DATA;
                emit_byte = char_reg;
                emit_last = 1'b1;
                st_we     = out_free;
                st_addr   = ADDR_W'(ADDR_W'(newest_reg) * ADDR_W'(COLS)
                            + ADDR_W'(column_reg));
                st_data   = char_reg;
            end
            default: begin
            end
        endcase
    end

    // Sequencer and position registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            column_reg <= '0;
            newest_reg <= '0;
            line_reg   <= '0;
            cnt_reg    <= '0;
            addr_reg   <= '0;
            pend_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (accept) begin
                pend_reg <= (s_char_in != NEWLINE_CHAR);
                if (scroll_req) begin
                    newest_reg <= newest_adv;
                    addr_reg   <= start_addr;
                    line_reg   <= '0;
                    cnt_reg    <= '0;
                end
            end
            if (state_reg == ST_DATA && out_free) begin
                addr_reg <= addr_inc;
                if (last_col) begin
                    cnt_reg  <= '0;
                    line_reg <= line_reg + 1'b1;
                end else begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
            if (state_reg == ST_FINAL && out_free) begin
                column_reg <= '0;
            end
            if (state_reg == ST_CHAR && out_free) begin
                column_reg <= column_reg + 1'b1;
            end
        end
    end

    // Character hold
    always_ff @(posedge aclk) begin
        if (accept) begin
            char_reg <= s_char_in;
        end
    end

    // Line store, reset to spaces
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DEPTH; i++) begin
                store_reg[i] <= SPACE_CHAR;
            end
        end else if (st_we) begin
            store_reg[st_addr] <= st_data;
        end
    end

    // Output word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_reg_sel_reg  <= emit_sel;
            m_bus_byte_reg <= emit_byte;
            m_last_reg     <= emit_last;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_reg_sel  = m_reg_sel_reg;
    assign m_bus_byte = m_bus_byte_reg;
    assign m_last     = m_last_reg;

    // Checks
    a_column_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        column_reg <= COL_W'(COLS))
        else $error("column beyond line length");

    a_newest_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        newest_reg <= ROW_W'(ROWS - 1))
        else $error("newest row out of range");

    a_addr_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DATA) |-> (addr_reg <= ADDR_W'(DEPTH - 1)))
        else $error("redraw address out of range");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready)
        else $error("ready while a character is in progress");

    a_last_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && emit_last) |=> (state_reg == ST_IDLE))
        else $error("final word issued but sequencer not idle");

endmodule

@@ tb/tb.sv @@
// Testbench: drives characters into the LCD scrolling console and checks every bus word.
`timescale 1ns / 1ps

module tb;
    import clsc_pkg::*;

    localparam int RAND_ITEMS  = 86;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYC   = 60;
    localparam int IDLE_PCT    = 32;

    // one bus word as seen on the m_ channel
    typedef struct packed {
        logic       rs;
        logic [7:0] bbyte;
        logic       last;
    } lcd_word_t;

    // directed stimulus row; typed rows carry a single expected data word
    typedef struct {
        logic [7:0] ch;
        bit         typed;
        logic [7:0] t_byte;
    } dir_row_t;

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       s_valid   = 1'b0;
    logic       s_ready;
    logic [7:0] s_char_in = 8'h00;
    logic       m_valid;
    logic       m_ready   = 1'b0;
    logic       m_reg_sel;
    logic [7:0] m_bus_byte;
    logic       m_last;

    // predictor state
    logic [7:0]     disp_store [DEPTH];
    logic [4:0]     disp_col;
    logic [ROW_W-1:0] disp_newest;

    lcd_word_t  lcd_expect[$];
    lcd_word_t  burst[$];
    lcd_word_t  exp_w;
    dir_row_t   dir_tab[$];
    bit         calm = 1'b0;
    int         err_cnt = 0;
    int         cycle_cnt = 0;

    char_lcd_scrolling_console_core i_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_char_in  (s_char_in),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_reg_sel  (m_reg_sel),
        .m_bus_byte (m_bus_byte),
        .m_last     (m_last)
    );

    always #10 aclk = ~aclk;

    // run limit
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    task automatic put_word(input logic rs, input logic [7:0] b);
        lcd_word_t w;
        w.rs    = rs;
        w.bbyte = b;
        w.last  = 1'b0;
        burst.push_back(w);
    endtask

    task automatic console_reset();
        for (int i = 0; i < DEPTH; i++) disp_store[i] = SPACE_CHAR;
        disp_col    = '0;
        disp_newest = '0;
    endtask

    // new line: clear it, redraw oldest to newest, park cursor on bottom line
    task automatic console_scroll();
        int row;
        disp_newest = ROW_W'((int'(disp_newest) + 1) % ROWS);
        for (int c = 0; c < COLS; c++) disp_store[int'(disp_newest) * COLS + c] = SPACE_CHAR;
        for (int d = 0; d < ROWS; d++) begin
            row = (int'(disp_newest) + 1 + d) % ROWS;
            put_word(RS_CMD, 8'(int'(CMD_SET_ADDR) + d * int'(LINE_OFFSET)));
            for (int c = 0; c < COLS; c++) put_word(RS_DATA, disp_store[row * COLS + c]);
        end
        disp_col = '0;
        put_word(RS_CMD, 8'(int'(CMD_SET_ADDR) + (ROWS - 1) * int'(LINE_OFFSET)));
    endtask

    // advance the console for one character; queue its words when keep is set
    task automatic console_step(input logic [7:0] ch, input bit keep);
        burst.delete();
        if (ch == NEWLINE_CHAR) begin
            console_scroll();
        end else begin
            if (int'(disp_col) >= COLS) console_scroll();
            disp_store[int'(disp_newest) * COLS + int'(disp_col)] = ch;
            disp_col = disp_col + 5'd1;
            put_word(RS_DATA, ch);
        end
        burst[burst.size() - 1].last = 1'b1;
        if (keep) foreach (burst[i]) lcd_expect.push_back(burst[i]);
    endtask

    // hand one character to the block; returns at the accepting edge
    task automatic send_char(input logic [7:0] ch, input bit typed, input logic [7:0] t_byte);
        lcd_word_t w;
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_char_in <= ch;
        do @(posedge aclk); while (!s_ready);
        console_step(ch, !typed);
        if (typed) begin
            w.rs    = RS_DATA;
            w.bbyte = t_byte;
            w.last  = 1'b1;
            lcd_expect.push_back(w);
        end
    endtask

    task automatic add_row(input logic [7:0] ch, input bit typed, input logic [7:0] t_byte);
        dir_row_t r;
        r.ch     = ch;
        r.typed  = typed;
        r.t_byte = t_byte;
        dir_tab.push_back(r);
    endtask

    // receiver backpressure
    always @(posedge aclk) begin
        m_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // word checker
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (lcd_expect.size() == 0) begin
                $display("%0t: unexpected word rs=%0b byte=%02h last=%0b",
                         $time, m_reg_sel, m_bus_byte, m_last);
                err_cnt++;
            end else begin
                exp_w = lcd_expect.pop_front();
                if (m_reg_sel !== exp_w.rs) begin
                    $display("%0t: reg_sel expected %0b actual %0b", $time, exp_w.rs, m_reg_sel);
                    err_cnt++;
                end
                if (m_bus_byte !== exp_w.bbyte) begin
                    $display("%0t: bus_byte expected %02h actual %02h",
                             $time, exp_w.bbyte, m_bus_byte);
                    err_cnt++;
                end
                if (m_last !== exp_w.last) begin
                    $display("%0t: last expected %0b actual %0b", $time, exp_w.last, m_last);
                    err_cnt++;
                end
            end
        end
    end

    // stimulus
    initial begin
        logic [7:0] ch;
        int         r;

        console_reset();

        // extremes after reset, then blank scrolls
        add_row(8'h00, 1'b1, 8'h00);
        add_row(8'hFF, 1'b1, 8'hFF);
        add_row(NEWLINE_CHAR, 1'b0, 8'h00);
        add_row(NEWLINE_CHAR, 1'b0, 8'h00);
        // fill one line to the last column, control codes and high bytes among them
        add_row(8'h09, 1'b0, 8'h00);
        add_row(8'h0B, 1'b0, 8'h00);
        add_row(8'h0D, 1'b0, 8'h00);
        add_row(8'h7F, 1'b0, 8'h00);
        add_row(8'h80, 1'b0, 8'h00);
        add_row(SPACE_CHAR, 1'b0, 8'h00);
        for (int i = 0; i < 10; i++) add_row(8'h41 + 8'(i), 1'b0, 8'h00);
        // full line wraps, then newlines around two characters on a fresh line
        add_row(8'h5A, 1'b0, 8'h00);
        add_row(NEWLINE_CHAR, 1'b0, 8'h00);
        add_row(8'h55, 1'b0, 8'h00);
        add_row(8'hAA, 1'b0, 8'h00);
        add_row(NEWLINE_CHAR, 1'b0, 8'h00);

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_tab[i]) send_char(dir_tab[i].ch, dir_tab[i].typed, dir_tab[i].t_byte);

        // random text: mostly printable, some newlines and raw bytes
        for (int i = 0; i < RAND_ITEMS; i++) begin
            calm = (i >= 40 && i < 70);
            r = $urandom_range(0, 99);
            if (r < 10)      ch = NEWLINE_CHAR;
            else if (r < 30) ch = 8'($urandom_range(0, 255));
            else             ch = 8'($urandom_range(32, 126));
            send_char(ch, 1'b0, 8'h00);
        end
        calm = 1'b0;
        s_valid <= 1'b0;

        // drain and watch for stray words
        while (lcd_expect.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYC) @(posedge aclk);

        if (err_cnt == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
